// ----- sv/cbrsf_pkg.sv -----
// ----------------------------------------------------------------------------
// cbrsf_pkg
// Shared constants, types and helper functions for the cluster bitmap block.
// ----------------------------------------------------------------------------
package cbrsf_pkg;

  localparam int unsigned MAX_CLUSTERS  = 65536;
  localparam int unsigned FIRST_CLUSTER = 2;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_BW = $clog2(WORD_W);
  localparam int unsigned WORDS   = (MAX_CLUSTERS + WORD_W - 1) / WORD_W;
  localparam int unsigned BIT_AW  = $clog2(MAX_CLUSTERS);
  localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam int unsigned CNT_W   = 17;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned CLUS_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FOUND_W = 17;
  localparam int unsigned WIDE_W  = CLUS_W + 2;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [WORD_AW-1:0] word_addr_t;
  typedef logic [BIT_AW-1:0]  bit_idx_t;
  typedef logic [WORD_BW-1:0] bit_ofs_t;
  typedef logic [WIDE_W-1:0]  wide_t;

  localparam logic [FUNC_W-1:0] FUNC_SET      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND_CLR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND_SET = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NONE   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

  typedef enum logic [1:0] {
    RES_OK,
    RES_NONE,
    RES_REJECT,
    RES_FOUND
  } res_e;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic clr_wr;
    logic widx_load;
    logic widx_inc;
    logic set_wr_ones;
    logic set_rd;
    logic set_rmw;
    logic scan_rd;
    logic res_ld;
    res_e res_sel;
    logic out_ld;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_set;
    logic is_find;
    logic set_ok;
    logic len_zero;
    logic scan_none;
    logic word_full;
    logic widx_last;
    logic clr_last;
    logic hit;
  } sts_t;

  // ones from bit lo up to bit hi, inclusive
  function automatic word_t range_mask(bit_ofs_t lo, bit_ofs_t hi);
    bit_ofs_t top;
    top = bit_ofs_t'(WORD_W - 1);
    return ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (top - hi));
  endfunction

  function automatic bit_ofs_t first_one(word_t w);
    bit_ofs_t idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = bit_ofs_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/cbrsf_if.sv -----
// ----------------------------------------------------------------------------
// cbrsf_req_if / cbrsf_rsp_if
// Valid/ready channels for requests and results of the cluster bitmap block.
// ----------------------------------------------------------------------------
interface cbrsf_req_if;
  logic                           valid;
  logic                           ready;
  logic [cbrsf_pkg::FUNC_W-1:0]   func;
  logic [cbrsf_pkg::CLUS_W-1:0]   start_cluster;
  logic [cbrsf_pkg::CLUS_W-1:0]   run_length;

  modport source (output valid, func, start_cluster, run_length, input ready);
  modport sink   (input valid, func, start_cluster, run_length, output ready);
endinterface

interface cbrsf_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cbrsf_pkg::STAT_W-1:0]   status;
  logic [cbrsf_pkg::FOUND_W-1:0]  found_cluster;

  modport source (output valid, status, found_cluster, input ready);
  modport sink   (input valid, status, found_cluster, output ready);
endinterface

// ----- sv/cbrsf_ram.sv -----
// ----------------------------------------------------------------------------
// cbrsf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbrsf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cbrsf_dp.sv -----
// ----------------------------------------------------------------------------
// cbrsf_dp
// Datapath: request registers, range checks, bitmap RAM, word masks, scan
// evaluation and result/output registers.
// ----------------------------------------------------------------------------
module cbrsf_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cbrsf_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic [cbrsf_pkg::FUNC_W-1:0]     func_i,
  input  logic [cbrsf_pkg::CLUS_W-1:0]     start_cluster_i,
  input  logic [cbrsf_pkg::CLUS_W-1:0]     run_length_i,
  input  cbrsf_pkg::cmd_t                  cmd_i,
  output cbrsf_pkg::sts_t                  sts_o,
  output logic [cbrsf_pkg::STAT_W-1:0]     status_o,
  output logic [cbrsf_pkg::FOUND_W-1:0]    found_cluster_o
);

  localparam cbrsf_pkg::wide_t First  = cbrsf_pkg::WIDE_W'(cbrsf_pkg::FIRST_CLUSTER);
  localparam cbrsf_pkg::wide_t First1 = cbrsf_pkg::WIDE_W'(cbrsf_pkg::FIRST_CLUSTER + 1);
  localparam cbrsf_pkg::wide_t MaxN   = cbrsf_pkg::WIDE_W'(cbrsf_pkg::MAX_CLUSTERS);

  logic [cbrsf_pkg::CNT_W-1:0]   cnt_q;
  logic [cbrsf_pkg::FUNC_W-1:0]  func_q;
  logic [cbrsf_pkg::CLUS_W-1:0]  start_q;
  logic [cbrsf_pkg::CLUS_W-1:0]  len_q;
  cbrsf_pkg::word_addr_t         widx_q;
  cbrsf_pkg::word_addr_t         rd_widx_q;
  logic                          rd_vld_q;
  logic [cbrsf_pkg::STAT_W-1:0]  res_status_q;
  logic [cbrsf_pkg::FOUND_W-1:0] res_found_q;
  logic [cbrsf_pkg::STAT_W-1:0]  out_status_q;
  logic [cbrsf_pkg::FOUND_W-1:0] out_found_q;

  cbrsf_pkg::wide_t      n_w, start_w, sum_w, p_w, found_w;
  cbrsf_pkg::bit_idx_t   s_bit, e_bit, p_bit, nl_bit;
  cbrsf_pkg::word_addr_t set_ws, set_we, scan_ws, scan_we, start_word, end_word;
  cbrsf_pkg::bit_ofs_t   set_lo, set_hi, n_lo;
  cbrsf_pkg::word_t      set_mask, scan_lo_mask, scan_hi_mask, rdata, cand, wdata;
  logic                  is_set, is_find, want_one, start_ok, last_ok, ram_we, ram_re;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q  <= func_i;
      start_q <= start_cluster_i;
      len_q   <= run_length_i;
    end
  end

  // range checks, all in widened arithmetic so nothing wraps
  always_comb begin
    n_w      = (cbrsf_pkg::WIDE_W'(cnt_q) > MaxN) ? MaxN : cbrsf_pkg::WIDE_W'(cnt_q);
    start_w  = cbrsf_pkg::WIDE_W'(start_q);
    sum_w    = start_w + cbrsf_pkg::WIDE_W'(len_q);
    start_ok = (start_w >= First) && (start_w < n_w + First);
    last_ok  = (sum_w >= First1) && (sum_w < n_w + First1);
    p_w      = (start_w < First) ? '0 : start_w - First;
    s_bit    = cbrsf_pkg::bit_idx_t'(start_w - First);
    e_bit    = cbrsf_pkg::bit_idx_t'(sum_w - First1);
    p_bit    = cbrsf_pkg::bit_idx_t'(p_w);
    nl_bit   = cbrsf_pkg::bit_idx_t'(n_w - cbrsf_pkg::WIDE_W'(1));
    n_lo     = n_w[cbrsf_pkg::WORD_BW-1:0];
    set_ws   = cbrsf_pkg::WORD_AW'(s_bit >> cbrsf_pkg::WORD_BW);
    set_we   = cbrsf_pkg::WORD_AW'(e_bit >> cbrsf_pkg::WORD_BW);
    scan_ws  = cbrsf_pkg::WORD_AW'(p_bit >> cbrsf_pkg::WORD_BW);
    scan_we  = cbrsf_pkg::WORD_AW'(nl_bit >> cbrsf_pkg::WORD_BW);
    is_set   = (func_q == cbrsf_pkg::FUNC_SET);
    is_find  = (func_q == cbrsf_pkg::FUNC_FIND_CLR) || (func_q == cbrsf_pkg::FUNC_FIND_SET);
    want_one = (func_q == cbrsf_pkg::FUNC_FIND_SET);
    start_word = is_set ? set_ws : scan_ws;
    end_word   = is_set ? set_we : scan_we;
  end

  // mask of the run inside the current word
  always_comb begin
    set_lo   = (widx_q == set_ws) ? s_bit[cbrsf_pkg::WORD_BW-1:0] : '0;
    set_hi   = (widx_q == set_we) ? e_bit[cbrsf_pkg::WORD_BW-1:0] : '1;
    set_mask = cbrsf_pkg::range_mask(set_lo, set_hi);
  end

  // word counter: clear pass, run walk, scan walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.widx_load) begin
        widx_q <= start_word;
      end else if (cmd_i.widx_inc) begin
        widx_q <= widx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_widx_q <= widx_q;
    end
  end

  assign ram_we = cmd_i.clr_wr | cmd_i.set_wr_ones | cmd_i.set_rmw;
  assign ram_re = cmd_i.set_rd | cmd_i.scan_rd;

  always_comb begin
    if (cmd_i.clr_wr) begin
      wdata = '0;
    end else if (cmd_i.set_wr_ones) begin
      wdata = '1;
    end else begin
      wdata = rdata | set_mask;
    end
  end

  cbrsf_ram #(
    .WIDTH (cbrsf_pkg::WORD_W),
    .DEPTH (cbrsf_pkg::WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (widx_q),
    .rdata_o (rdata)
  );

  // scan evaluation on the word returned by the RAM
  always_comb begin
    scan_lo_mask = (rd_widx_q == scan_ws) ?
                   cbrsf_pkg::range_mask(p_bit[cbrsf_pkg::WORD_BW-1:0], '1) : '1;
    scan_hi_mask = ((rd_widx_q == scan_we) && (n_lo != '0)) ?
                   cbrsf_pkg::range_mask('0, n_lo - 1'b1) : '1;
    cand    = (want_one ? rdata : ~rdata) & scan_lo_mask & scan_hi_mask;
    found_w = cbrsf_pkg::WIDE_W'({rd_widx_q, cbrsf_pkg::first_one(cand)}) + First;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      case (cmd_i.res_sel)
        cbrsf_pkg::RES_OK: begin
          res_status_q <= cbrsf_pkg::STATUS_OK;
          res_found_q  <= '0;
        end
        cbrsf_pkg::RES_NONE: begin
          res_status_q <= cbrsf_pkg::STATUS_NONE;
          res_found_q  <= '0;
        end
        cbrsf_pkg::RES_FOUND: begin
          res_status_q <= cbrsf_pkg::STATUS_OK;
          res_found_q  <= cbrsf_pkg::FOUND_W'(found_w);
        end
        default: begin
          res_status_q <= cbrsf_pkg::STATUS_REJECT;
          res_found_q  <= '0;
        end
      endcase
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  always_comb begin
    sts_o.is_set    = is_set;
    sts_o.is_find   = is_find;
    sts_o.set_ok    = start_ok && last_ok;
    sts_o.len_zero  = (len_q == '0);
    sts_o.scan_none = (p_w >= n_w);
    sts_o.word_full = &set_mask;
    sts_o.widx_last = (widx_q == end_word);
    sts_o.clr_last  = (widx_q == cbrsf_pkg::WORD_AW'(cbrsf_pkg::WORDS - 1));
    sts_o.hit       = rd_vld_q && (|cand);
  end

  assign status_o        = out_status_q;
  assign found_cluster_o = out_found_q;

endmodule

// ----- sv/cbrsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbrsf_ctrl
// Controller: clear pass, request decode, run marking, bitmap scan and
// result hand-off.
// ----------------------------------------------------------------------------
module cbrsf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  cbrsf_pkg::sts_t sts_i,
  output cbrsf_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SET_WR,
    ST_SET_RMW,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr   = 1'b1;
        cmd_o.widx_inc = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.is_set) begin
          if (!sts_i.set_ok) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = cbrsf_pkg::RES_REJECT;
            state_d       = ST_DONE;
          end else if (sts_i.len_zero) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = cbrsf_pkg::RES_OK;
            state_d       = ST_DONE;
          end else begin
            cmd_o.widx_load = 1'b1;
            state_d         = ST_SET_WR;
          end
        end else if (sts_i.is_find) begin
          if (sts_i.scan_none) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = cbrsf_pkg::RES_NONE;
            state_d       = ST_DONE;
          end else begin
            cmd_o.widx_load = 1'b1;
            state_d         = ST_SCAN;
          end
        end else begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = cbrsf_pkg::RES_REJECT;
          state_d       = ST_DONE;
        end
      end
      ST_SET_WR: begin
        // fully covered words are written whole; partially covered edge words need read-modify-write
        if (sts_i.word_full) begin
          cmd_o.set_wr_ones = 1'b1;
          if (sts_i.widx_last) begin
            cmd_o.res_ld  = 1'b1;
            cmd_o.res_sel = cbrsf_pkg::RES_OK;
            state_d       = ST_DONE;
          end else begin
            cmd_o.widx_inc = 1'b1;
          end
        end else begin
          cmd_o.set_rd = 1'b1;
          state_d      = ST_SET_RMW;
        end
      end
      ST_SET_RMW: begin
        cmd_o.set_rmw = 1'b1;
        if (sts_i.widx_last) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = cbrsf_pkg::RES_OK;
          state_d       = ST_DONE;
        end else begin
          cmd_o.widx_inc = 1'b1;
          state_d        = ST_SET_WR;
        end
      end
      ST_SCAN: begin
        // hit refers to the word read in the cycle before
        if (sts_i.hit) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = cbrsf_pkg::RES_FOUND;
          state_d       = ST_DONE;
        end else begin
          cmd_o.scan_rd = 1'b1;
          if (sts_i.widx_last) begin
            state_d = ST_DRAIN;
          end else begin
            cmd_o.widx_inc = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_sel = sts_i.hit ? cbrsf_pkg::RES_FOUND : cbrsf_pkg::RES_NONE;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

endmodule

// ----- sv/cluster_bitmap_range_set_and_find.sv -----
// ----------------------------------------------------------------------------
// cluster_bitmap_range_set_and_find
// Cluster allocation bitmap with range set and find-first-clear/set scan.
// ----------------------------------------------------------------------------
// Requests arrive as words on req_i (func, start_cluster, run_length) and each
// one gives exactly one result word on rsp_o (status, found_cluster). Valid
// clusters are 2 .. cluster_count + 1; cluster_count is written through
// cfg_we_i / cfg_wdata_i while the block is idle, a rule for the user that
// the block itself does not enforce. The bitmap sits in a RAM of 64-bit words;
// one request is worked at a time. After reset the block clears all 1024 words
// of the RAM one word a cycle with req_i.ready low; cluster_count resets to 0.
// A rejected, zero-length or empty-find request has its result loaded right
// after the check. A set writes fully covered words of the run whole and
// updates partially covered edge words by read-modify-write through the RAM
// port. A find reads the words one word per cycle, up to 1024 words.
// The next request is taken only once the result has moved to the output
// register and the controller is idle again; requests are not overlapped.
// A result waits in an output register; the next request is accepted and
// worked while it is stalled, and its result is held in the result register
// until the output register frees up.
// ----------------------------------------------------------------------------
module cluster_bitmap_range_set_and_find (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cbrsf_req_if.sink                    req_i,
  cbrsf_rsp_if.source                  rsp_o,
  input  logic                         cfg_we_i,
  input  logic [cbrsf_pkg::CNT_W-1:0]  cfg_wdata_i
);

  cbrsf_pkg::cmd_t cmd;
  cbrsf_pkg::sts_t sts;

  cbrsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cbrsf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (req_i.func),
    .start_cluster_i (req_i.start_cluster),
    .run_length_i    (req_i.run_length),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (rsp_o.status),
    .found_cluster_o (rsp_o.found_cluster)
  );

  // one request in flight at a time
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one still in work");

  // a nonzero cluster only comes with a successful find
  a_found_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.found_cluster != '0)) |->
      (rsp_o.status == cbrsf_pkg::STATUS_OK))
    else $error("found cluster reported with failing status");

  a_found_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.found_cluster != '0)) |->
      (rsp_o.found_cluster >= cbrsf_pkg::FOUND_W'(cbrsf_pkg::FIRST_CLUSTER)))
    else $error("found cluster below first data cluster");

endmodule
